// ===== rtl/core/rtcm3_pkg.sv =====
// Package for the RTCM 3 frame sync and CRC-24Q check block.
// Types, codes and constants shared by the core, its submodules and the checker.
// No dependencies.
package rtcm3_pkg;

  localparam logic [7:0]  PREAMBLE      = 8'hD3;
  localparam logic [24:0] CRC_POLY      = 25'h1864CFB;
  localparam int          HDR_DEPTH     = 10;
  localparam int          CNT_W         = 11;
  localparam logic [CNT_W-1:0] MSM7_MIN_LEN  = CNT_W'(25);
  localparam logic [30:0] BDS_OFFSET_MS = 31'd14000;

  // MSM7 message types
  localparam logic [11:0] MT_GPS_MSM7 = 12'd1077;
  localparam logic [11:0] MT_GLO_MSM7 = 12'd1087;
  localparam logic [11:0] MT_GAL_MSM7 = 12'd1097;
  localparam logic [11:0] MT_BDS_MSM7 = 12'd1127;

  typedef logic [7:0] byte_t;

  // frame bytes 3..9, byte 3 in the top bits
  typedef logic [7*8-1:0] body_t;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_IN_FRAME = 3'd1,
    ST_PAR_ERR  = 3'd2,
    ST_FRAME_OK = 3'd3,
    ST_MSM7     = 3'd4
  } status_t;

  // decoder results for one finished frame
  typedef struct packed {
    logic [11:0] msg_type;
    logic [7:0]  msg_subtype;
    logic        is_msm7;
    logic        time_load;
    logic [30:0] tow_ms;
  } decode_t;

endpackage

// ===== rtl/core/rtcm3_frame_sync_crc_check.sv =====
// RTCM 3 frame synchronizer with CRC-24Q check and MSM7 epoch decode (top level).
// Depends on rtcm3_pkg, rtcm3_crc24q and rtcm3_msm7_decode.
//
// One received byte in, one status item out, for every byte. The block hunts for
// the 0xD3 preamble, takes the 10-bit length, runs CRC-24Q over header and payload
// and checks it against the three parity bytes. A good frame updates the held type,
// subtype and, for full-length MSM7 frames, the time of week. Throughput is one byte
// per clock unless the output stalls: the CRC byte update, counters and field decode
// sit between the input transfer and a single result register. A new byte is taken
// whenever the result register is empty or being drained in the same cycle. The held
// fields on the out_ ports belong to the status item currently presented.
module rtcm3_frame_sync_crc_check (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rtcm3_pkg::byte_t            in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_status,
  output logic [11:0]                 out_message_type,
  output logic [7:0]                  out_message_subtype,
  output logic [30:0]                 out_time_of_week_ms
);
  import rtcm3_pkg::*;

  logic [CNT_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [CNT_W-1:0] frame_len_r, frame_len_nxt;
  logic [23:0]      crc_r, crc_nxt;
  logic [23:0]      par_r, par_nxt;
  byte_t            hdr_r [HDR_DEPTH];
  byte_t            hdr_cur [HDR_DEPTH];
  logic [11:0]      type_r, type_nxt;
  logic [7:0]       subtype_r, subtype_nxt;
  logic [30:0]      tow_r, tow_nxt;
  status_t          status_r, status_nxt;
  logic             out_valid_r;

  logic             in_xfer;
  logic [23:0]      crc_seed;
  logic [23:0]      crc_upd;
  logic [23:0]      crc_acc;
  logic [23:0]      par_acc;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W:0]   end_pos;
  body_t            body;
  decode_t          dec;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_status          = status_r;
  assign out_message_type    = type_r;
  assign out_message_subtype = subtype_r;
  assign out_time_of_week_ms = tow_r;

  // header store as seen after this byte is written
  always_comb begin
    for (int i = 0; i < HDR_DEPTH; i++) begin
      hdr_cur[i] = (byte_cnt_r == CNT_W'(i)) ? in_rx_byte : hdr_r[i];
    end
    for (int i = 3; i < HDR_DEPTH; i++) begin
      body[(HDR_DEPTH-1-i)*8 +: 8] = hdr_cur[i];
    end
  end

  assign crc_seed = (byte_cnt_r == '0) ? 24'h000000 : crc_r;

  rtcm3_crc24q u_crc (
    .crc_in  (crc_seed),
    .data_in (in_rx_byte),
    .crc_out (crc_upd)
  );

  rtcm3_msm7_decode u_dec (
    .body      (body),
    .frame_len (frame_len_nxt),
    .dec       (dec)
  );

  // frame tracking
  always_comb begin
    byte_cnt_nxt  = byte_cnt_r;
    frame_len_nxt = frame_len_r;
    crc_nxt       = crc_r;
    par_nxt       = par_r;
    type_nxt      = type_r;
    subtype_nxt   = subtype_r;
    tow_nxt       = tow_r;
    status_nxt    = ST_IDLE;
    crc_acc       = crc_r;
    par_acc       = par_r;
    cnt_inc       = byte_cnt_r + CNT_W'(1);
    end_pos       = '0;
    if (byte_cnt_r == '0) begin
      if (in_rx_byte == PREAMBLE) begin
        crc_nxt      = crc_upd;
        par_nxt      = '0;
        byte_cnt_nxt = CNT_W'(1);
      end
    end else begin
      if (byte_cnt_r < CNT_W'(3) || byte_cnt_r < frame_len_r) begin
        crc_acc = crc_upd;
      end else begin
        par_acc = {par_r[15:0], in_rx_byte};
      end
      if (byte_cnt_r == CNT_W'(2)) begin
        frame_len_nxt = CNT_W'({hdr_r[1][1:0], in_rx_byte}) + CNT_W'(3);
      end
      end_pos = {1'b0, frame_len_nxt} + (CNT_W+1)'(3);
      if (cnt_inc < CNT_W'(3) || {1'b0, cnt_inc} < end_pos) begin
        status_nxt   = ST_IN_FRAME;
        byte_cnt_nxt = cnt_inc;
        crc_nxt      = crc_acc;
        par_nxt      = par_acc;
      end else begin
        if (par_acc != crc_acc) begin
          status_nxt = ST_PAR_ERR;
        end else begin
          type_nxt    = dec.msg_type;
          subtype_nxt = dec.msg_subtype;
          status_nxt  = dec.is_msm7 ? ST_MSM7 : ST_FRAME_OK;
          if (dec.time_load) begin
            tow_nxt = dec.tow_ms;
          end
        end
        byte_cnt_nxt = '0;
        crc_nxt      = '0;
        par_nxt      = '0;
      end
    end
  end

  // control and held state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r  <= '0;
      frame_len_r <= '0;
      crc_r       <= '0;
      par_r       <= '0;
      type_r      <= '0;
      subtype_r   <= '0;
      tow_r       <= '0;
      status_r    <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        byte_cnt_r  <= byte_cnt_nxt;
        frame_len_r <= frame_len_nxt;
        crc_r       <= crc_nxt;
        par_r       <= par_nxt;
        type_r      <= type_nxt;
        subtype_r   <= subtype_nxt;
        tow_r       <= tow_nxt;
        status_r    <= status_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // header byte store, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < HDR_DEPTH; i++) begin
        if (byte_cnt_r == CNT_W'(i) && (i != 0 || in_rx_byte == PREAMBLE)) begin
          hdr_r[i] <= hdr_cur[i];
        end
      end
    end
  end

endmodule

// ===== rtl/core/rtcm3_crc24q.sv =====
// Byte-wide CRC-24Q update (polynomial 0x1864CFB), MSB first.
// Depends on rtcm3_pkg.
module rtcm3_crc24q (
  input  logic [23:0]         crc_in,
  input  rtcm3_pkg::byte_t    data_in,
  output logic [23:0]         crc_out
);
  import rtcm3_pkg::*;

  // eight shift-and-reduce steps on a 25-bit working value
  always_comb begin
    logic [24:0] acc;
    acc = {1'b0, crc_in ^ {data_in, 16'h0000}};
    for (int k = 0; k < 8; k++) begin
      acc = {acc[23:0], 1'b0};
      if (acc[24]) begin
        acc = acc ^ CRC_POLY;
      end
    end
    crc_out = acc[23:0];
  end

endmodule

// ===== rtl/core/rtcm3_msm7_decode.sv =====
// Field extraction for a good frame: type, subtype and MSM7 epoch time.
// Depends on rtcm3_pkg.
module rtcm3_msm7_decode (
  input  rtcm3_pkg::body_t          body,
  input  logic [rtcm3_pkg::CNT_W-1:0] frame_len,
  output rtcm3_pkg::decode_t        dec
);
  import rtcm3_pkg::*;

  logic [11:0] msg_type;
  logic [31:0] word;
  logic [29:0] tow30;

  assign msg_type = body[55:44];
  assign word     = body[31:0];
  assign tow30    = word[31:2];

  always_comb begin
    dec.msg_type    = msg_type;
    dec.msg_subtype = body[43:36];
    dec.is_msm7     = (msg_type == MT_GPS_MSM7) || (msg_type == MT_GLO_MSM7) ||
                      (msg_type == MT_GAL_MSM7) || (msg_type == MT_BDS_MSM7);
    dec.time_load   = dec.is_msm7 && (frame_len >= MSM7_MIN_LEN);
    // GLONASS drops the day-of-week bits, BeiDou is moved to the GPS time base
    if (msg_type == MT_GLO_MSM7) begin
      dec.tow_ms = {4'd0, tow30[26:0]};
    end else if (msg_type == MT_BDS_MSM7) begin
      dec.tow_ms = {1'b0, tow30} + BDS_OFFSET_MS;
    end else begin
      dec.tow_ms = {1'b0, tow30};
    end
  end

endmodule

// ===== rtl/core/rtcm3_frame_sync_crc_check_chk.sv =====
// Port-level checker for rtcm3_frame_sync_crc_check, with its bind statement.
// Depends on rtcm3_pkg.
module rtcm3_frame_sync_crc_check_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [11:0] out_message_type
);
  import rtcm3_pkg::*;

  logic [11:0] last_type_r;

  // type seen on the last delivered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_type_r <= '0;
    end else if (out_valid && out_ready) begin
      last_type_r <= out_message_type;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_message_type))
    else $error("stalled result changed");

  // every input transfer yields a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after input transfer");

  // an empty result slot never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result slot");

  // held type only moves on a good frame
  a_type_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_FRAME_OK && out_status != ST_MSM7 |->
    out_message_type == last_type_r)
    else $error("message type changed without good frame");

endmodule

bind rtcm3_frame_sync_crc_check rtcm3_frame_sync_crc_check_chk u_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_message_type (out_message_type)
);

// ===== tb/sv/rtcm3_checker.sv =====
// Scoreboard for the RTCM 3 frame sync / CRC-24Q block: tracks framing, CRC and
// field decode per input transfer, compares every result transfer in order.
// Depends on rtcm3_pkg.
`timescale 1ns / 100ps

module rtcm3_checker
  import rtcm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  byte_t       in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_status,
  input  logic [11:0] out_message_type,
  input  logic [7:0]  out_message_subtype,
  input  logic [30:0] out_time_of_week_ms,
  input  logic        check_end,
  output int          fail_count
);

  typedef struct packed {
    status_t     status;
    logic [11:0] mtype;
    logic [7:0]  subtype;
    logic [30:0] tow_ms;
  } status_report_t;

  // framer state
  logic [CNT_W-1:0] rx_count;
  logic [CNT_W-1:0] frame_len;
  logic [23:0]      crc_acc;
  logic [23:0]      parity_acc;
  byte_t            hdr [0:HDR_DEPTH-1];
  logic [11:0]      held_type;
  logic [7:0]       held_sub;
  logic [30:0]      held_tow;

  status_report_t status_reports [$];
  int             mismatch_count = 0;
  int             results_seen = 0;
  bit             end_checked = 1'b0;

  assign fail_count = mismatch_count;

  function automatic logic [23:0] crc24q_step(input logic [23:0] crc, input byte_t rx);
    logic [24:0] r;
    r = {1'b0, crc ^ {rx, 16'h0000}};
    for (int k = 0; k < 8; k++) begin
      r = r << 1;
      if (r[24]) r = r ^ CRC_POLY;
    end
    return r[23:0];
  endfunction

  // one received byte through the framer; queues the status item it yields
  task automatic advance_framer(input byte_t rx);
    logic [CNT_W-1:0] idx;
    logic [31:0]      word;
    status_report_t   rep;
    idx = rx_count;
    rep.status = ST_IDLE;
    if (idx == '0) begin
      // preamble hunt
      if (rx == PREAMBLE) begin
        hdr[0]     = rx;
        crc_acc    = crc24q_step(24'h000000, rx);
        parity_acc = '0;
        rx_count   = CNT_W'(1);
      end
    end else begin
      if (idx < HDR_DEPTH) hdr[idx] = rx;
      if (idx < 3 || idx < frame_len) crc_acc = crc24q_step(crc_acc, rx);
      else parity_acc = {parity_acc[15:0], rx};
      if (idx == 2) frame_len = CNT_W'({hdr[1][1:0], rx}) + CNT_W'(3);
      rx_count = idx + 1'b1;
      if (rx_count < 3 || rx_count < frame_len + CNT_W'(3)) begin
        rep.status = ST_IN_FRAME;
      end else begin
        // frame complete: parity check, then decode on a match
        if (parity_acc != crc_acc) begin
          rep.status = ST_PAR_ERR;
        end else begin
          held_type  = {hdr[3], hdr[4][7:4]};
          held_sub   = {hdr[4][3:0], hdr[5][7:4]};
          rep.status = ST_FRAME_OK;
          if (held_type == MT_GPS_MSM7 || held_type == MT_GLO_MSM7 ||
              held_type == MT_GAL_MSM7 || held_type == MT_BDS_MSM7) begin
            rep.status = ST_MSM7;
            // short MSM7 frame keeps the old epoch
            if (frame_len >= MSM7_MIN_LEN) begin
              word = {hdr[6], hdr[7], hdr[8], hdr[9]} >> 2;
              if (held_type == MT_GLO_MSM7) held_tow = {4'b0000, word[26:0]};
              else if (held_type == MT_BDS_MSM7) held_tow = 31'(word[29:0]) + BDS_OFFSET_MS;
              else held_tow = 31'(word[29:0]);
            end
          end
        end
        rx_count   = '0;
        crc_acc    = '0;
        parity_acc = '0;
      end
    end
    rep.mtype   = held_type;
    rep.subtype = held_sub;
    rep.tow_ms  = held_tow;
    status_reports.push_back(rep);
  endtask

  always @(posedge clk) begin : scoreboard
    status_report_t want;
    if (!rst_n) begin
      rx_count   = '0;
      frame_len  = '0;
      crc_acc    = '0;
      parity_acc = '0;
      held_type  = '0;
      held_sub   = '0;
      held_tow   = '0;
      for (int i = 0; i < HDR_DEPTH; i++) hdr[i] = '0;
      status_reports.delete();
    end else begin
      // result transfer first: it belongs to an earlier input transfer
      if (out_valid && out_ready) begin
        results_seen++;
        if (status_reports.size() == 0) begin
          if (mismatch_count < 10)
            $display("result %0d: no status item outstanding, got status %0d type %0d",
                     results_seen, out_status, out_message_type);
          mismatch_count++;
        end else begin
          want = status_reports.pop_front();
          if (out_status != want.status || out_message_type != want.mtype ||
              out_message_subtype != want.subtype || out_time_of_week_ms != want.tow_ms) begin
            if (mismatch_count < 10)
              $display("result %0d: exp st %0d type %0d sub %0d tow %0d, got st %0d type %0d sub %0d tow %0d",
                       results_seen, want.status, want.mtype, want.subtype, want.tow_ms,
                       out_status, out_message_type, out_message_subtype, out_time_of_week_ms);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) advance_framer(in_rx_byte);
      // anything still outstanding at the end is a miss
      if (check_end && !end_checked) begin
        end_checked = 1'b1;
        if (status_reports.size() != 0) begin
          $display("%0d status items never delivered", status_reports.size());
          mismatch_count += status_reports.size();
        end
      end
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the RTCM 3 frame sync / CRC-24Q testbench: clock, reset, byte stream of
// framed messages with noise and broken frames, flow control, verdict.
// Depends on rtcm3_pkg, rtcm3_frame_sync_crc_check and rtcm3_checker.
`timescale 1ns / 100ps

module testbench;
  import rtcm3_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_BYTES  = 1000;

  typedef enum int {FR_GOOD, FR_BITERR, FR_TRUNC} frame_kind_t;
  typedef enum int {PH_NONE, PH_SRC_IDLE, PH_SINK_STALL, PH_BOTH} idle_phase_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  byte_t       in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [11:0] out_message_type;
  logic [7:0]  out_message_subtype;
  logic [30:0] out_time_of_week_ms;
  logic        check_end;
  int          fail_count;

  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int in_count = 0;
  int out_count = 0;
  int quiet_cycles = 0;

  rtcm3_frame_sync_crc_check u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_message_type    (out_message_type),
    .out_message_subtype (out_message_subtype),
    .out_time_of_week_ms (out_time_of_week_ms)
  );

  rtcm3_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_message_type    (out_message_type),
    .out_message_subtype (out_message_subtype),
    .out_time_of_week_ms (out_time_of_week_ms),
    .check_end           (check_end),
    .fail_count          (fail_count)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // transfer counters and watchdog on stretches with no transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) in_count++;
      if (out_valid && out_ready) out_count++;
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [23:0] crc24q_next(input logic [23:0] crc, input byte_t rx);
    logic [24:0] r;
    r = {1'b0, crc ^ {rx, 16'h0000}};
    for (int k = 0; k < 8; k++) begin
      r = r << 1;
      if (r[24]) r = r ^ CRC_POLY;
    end
    return r[23:0];
  endfunction

  function automatic byte_t filler_byte();
    byte_t v;
    do v = byte_t'($urandom); while (v == PREAMBLE);
    return v;
  endfunction

  function automatic logic [11:0] pick_type();
    case ($urandom_range(9))
      0, 6:    return MT_GPS_MSM7;
      1, 7:    return MT_GLO_MSM7;
      2:       return MT_GAL_MSM7;
      3, 8:    return MT_BDS_MSM7;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 10) return $urandom_range(3, 0);
    else if (r < 40) return $urandom_range(21, 4);
    else if (r < 90) return $urandom_range(40, 22);
    else return $urandom_range(120, 41);
  endfunction

  // present one byte; in_valid stays high on return, caller decides what follows
  task automatic send_byte(input byte_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // build a frame with correct CRC, then corrupt or cut it as asked
  task automatic send_frame(input int len, input logic [11:0] mtype,
                            input frame_kind_t kind, output int sent);
    byte_t       fbuf [0:1028];
    logic [9:0]  len_field;
    logic [23:0] crc;
    byte_t       fill;
    int          total;
    int          stop;
    int          flip;
    total     = len + 6;
    len_field = len[9:0];
    fbuf[0]   = PREAMBLE;
    fbuf[1]   = {6'($urandom), len_field[9:8]};
    fbuf[2]   = len_field[7:0];
    for (int i = 3; i < total; i++) fbuf[i] = byte_t'($urandom);
    if (len >= 1) fbuf[3] = mtype[11:4];
    if (len >= 2) fbuf[4][7:4] = mtype[3:0];
    // occasionally all-zero or all-one epoch field
    if ($urandom_range(7) == 0) begin
      fill = $urandom_range(1) ? 8'hFF : 8'h00;
      for (int i = 6; i < 10 && i < len + 3; i++) fbuf[i] = fill;
    end
    crc = 24'h000000;
    for (int i = 0; i < len + 3; i++) crc = crc24q_next(crc, fbuf[i]);
    fbuf[len+3] = crc[23:16];
    fbuf[len+4] = crc[15:8];
    fbuf[len+5] = crc[7:0];
    stop = total;
    // bit errors stay past the length field so framing holds
    if (kind == FR_BITERR) begin
      flip = $urandom_range(total - 1, 3);
      fbuf[flip] = fbuf[flip] ^ (8'h01 << $urandom_range(7));
    end
    if (kind == FR_TRUNC) stop = $urandom_range(total - 1, 3);
    for (int i = 0; i < stop; i++) send_byte(fbuf[i]);
    // cut frame: non-preamble filler runs the framer back to hunting
    if (kind == FR_TRUNC) begin
      for (int i = 0; i < total; i++) send_byte(filler_byte());
    end
    sent = stop;
  endtask

  initial begin : stimulus
    int          rand_bytes;
    int          sent;
    int          r;
    bit          hold_issued;
    bit          pause_issued;
    bit          max_sent;
    idle_phase_t phase;
    rand_bytes   = 0;
    hold_issued  = 1'b0;
    pause_issued = 1'b0;
    max_sent     = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_rx_byte   = 8'h00;
    check_end    = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle bytes at the extremes, zero-length frame (type from parity),
    // parity error, short MSM7 frame that keeps the old epoch
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(0, 12'h000, FR_GOOD, sent);
    send_frame(0, 12'h000, FR_BITERR, sent);
    send_frame(3, MT_BDS_MSM7, FR_GOOD, sent);

    // random frames with noise and broken frames, idling phases in rotation
    while (rand_bytes < RAND_BYTES) begin
      phase = idle_phase_t'((rand_bytes / 50) % 4);
      case (phase)
        PH_NONE:       begin idle_pct = 0;  stall_pct = 0;  end
        PH_SRC_IDLE:   begin idle_pct = 51; stall_pct = 0;  end
        PH_SINK_STALL: begin idle_pct = 0;  stall_pct = 51; end
        default:       begin idle_pct = 31; stall_pct = 31; end
      endcase
      // long receiver hold-off while bytes keep coming
      if (!hold_issued && rand_bytes >= 50) begin
        hold_issued = 1'b1;
        hold_req    = 1'b1;
      end
      // sender drains the block before going on
      if (!pause_issued && rand_bytes >= 150) begin
        pause_issued = 1'b1;
        in_valid <= 1'b0;
        @(negedge clk);
        while (out_count != in_count) @(negedge clk);
      end
      r = $urandom_range(99);
      if (!max_sent && rand_bytes >= 200) begin
        max_sent = 1'b1;
        send_frame(1023, MT_GPS_MSM7, FR_GOOD, sent);
        rand_bytes += sent;
      end else if (r < 6) begin
        repeat ($urandom_range(8, 1)) send_byte(filler_byte());
      end else if (r < 14) begin
        send_frame($urandom_range(30, 0), pick_type(), FR_BITERR, sent);
        rand_bytes += sent;
      end else if (r < 20) begin
        send_frame($urandom_range(30, 0), pick_type(), FR_TRUNC, sent);
        rand_bytes += sent;
      end else begin
        send_frame(pick_len(), pick_type(), FR_GOOD, sent);
        rand_bytes += sent;
      end
    end

    // drain, let the pipeline settle, then verdict
    in_valid <= 1'b0;
    @(negedge clk);
    while (out_count != in_count) @(negedge clk);
    repeat (8) @(negedge clk);
    check_end = 1'b1;
    repeat (2) @(negedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
